// File: src/kwma_pkg.sv
// Package: shared constants, status codes and the search token type of the key whitelist.
`timescale 1ns / 1ps
`default_nettype none
package kwma_pkg;

    localparam int MAX_KEYS  = 128;
    localparam int KEY_BYTES = 7;

    localparam int KEY_W   = 56;
    localparam int STAT_W  = 3;
    localparam int KCNT_W  = 8;
    localparam int CNT_W   = $clog2(MAX_KEYS + 1);

    // bytes that take part in a match, clamped to one..seven
    localparam int CMP_BYTES = (KEY_BYTES > 7) ? 7 : ((KEY_BYTES < 1) ? 1 : KEY_BYTES);
    localparam logic [KEY_W-1:0] CMP_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * CMP_BYTES);

    localparam logic [STAT_W-1:0] ST_READ_ERR = 3'd0;
    localparam logic [STAT_W-1:0] ST_GRANTED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_DENIED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_ADDED    = 3'd3;
    localparam logic [STAT_W-1:0] ST_KNOWN    = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

    // search token walking down the cell row
    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] left;   // stored entries still ahead, counting this cell
        logic             hit;
    } tok_t;

endpackage
`default_nettype wire

// File: src/kwma_in_if.sv
// Interface: input channel carrying one key read word.
`timescale 1ns / 1ps
`default_nettype none
interface kwma_in_if;
    logic                       valid;
    logic                       ready;
    logic [kwma_pkg::KEY_W-1:0] key_id;
    logic                       read_ok;
    logic                       program_mode;

    modport source (output valid, output key_id, output read_ok, output program_mode,
                    input ready);
    modport sink   (input valid, input key_id, input read_ok, input program_mode,
                    output ready);
endinterface
`default_nettype wire

// File: src/kwma_out_if.sv
// Interface: output channel carrying one status word.
`timescale 1ns / 1ps
`default_nettype none
interface kwma_out_if;
    logic                        valid;
    logic                        ready;
    logic [kwma_pkg::STAT_W-1:0] status;
    logic [kwma_pkg::KCNT_W-1:0] key_count;

    modport source (output valid, output status, output key_count, input ready);
    modport sink   (input valid, input status, input key_count, output ready);
endinterface
`default_nettype wire

// File: src/kwma_cell.sv
// Cell: holds one stored key, compares it against the passing token and forwards the token.
`timescale 1ns / 1ps
`default_nettype none
module kwma_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire kwma_pkg::tok_t             tok_in,
    input  wire logic                       wr_en,
    input  wire logic [kwma_pkg::KEY_W-1:0] wr_key,
    output kwma_pkg::tok_t                  tok_out
);
    import kwma_pkg::*;

    logic [KEY_W-1:0] key_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             live;
    logic             match;

    // entry is in use only while the token still has stored entries ahead
    assign live  = (tok_in.left != '0);
    assign match = live && (((key_reg ^ tok_in.key) & CMP_MASK) == '0);

    always_comb
    begin
        tok_next      = tok_in;
        tok_next.hit  = tok_in.hit | match;
        tok_next.left = live ? tok_in.left - CNT_W'(1) : tok_in.left;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg <= wr_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

// File: src/key_whitelist_match_add_top.sv
// Top level: access-control key whitelist with lookup and enrollment over a row of key cells.
//
// Usage:
//   key_in  : one word per key read (key_id, read_ok, program_mode), valid/ready.
//   result  : one word per key read (status, key_count), valid/ready.
//   Keys live in a row of MAX_KEYS cells, one key per cell. A lookup launches a
//   token at the head of the row; it moves one cell per cycle and collects the
//   match flag from every cell that holds a stored key.
//   The result is registered: a good read's token passes the launch register
//   and every cell register down the row before its status is registered and
//   then loaded into the output register; a failed read skips the walk.
//   Only one key read is handled at a time; key_in is ready again once the
//   result has moved into the output register, so the next read may be
//   accepted while that result still waits.
//   Enrollment writes the new key into the cell at the current count when the
//   token leaves the row, and the count steps by one.
//   Reset clears the count and all control state; stored keys are not cleared
//   and are never read before being written.
//   A stalled receiver holds the result word; a finished lookup then waits in
//   place and key_in stays low until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module key_whitelist_match_add_top (
    input  wire logic clk,
    input  wire logic rst_n,
    kwma_in_if.sink   key_in,
    kwma_out_if.source result
);
    import kwma_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0] key_reg;
    logic             ok_reg;
    logic             prog_reg;
    logic [STAT_W-1:0] stat_reg, stat_next;
    tok_t             start_reg, start_next;

    logic             out_vld_reg, out_vld_next;
    logic [STAT_W-1:0] out_stat_reg;
    logic [KCNT_W-1:0] out_cnt_reg;

    tok_t             chain [MAX_KEYS+1];
    logic [MAX_KEYS-1:0] wr_sel;

    logic in_acc;
    logic tail_vld;
    logic table_full;
    logic wr_now;
    logic out_load;

    assign key_in.ready = (state_reg == S_IDLE);
    assign in_acc       = key_in.valid && key_in.ready;

    // cell row: token enters from the launch register, leaves at the tail
    assign chain[0] = start_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEYS; gi++)
        begin : g_cell
            assign wr_sel[gi] = wr_now && (cnt_reg == CNT_W'(gi));
            kwma_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (chain[gi]),
                .wr_en   (wr_sel[gi]),
                .wr_key  (key_reg),
                .tok_out (chain[gi+1])
            );
        end
    endgenerate

    assign tail_vld   = chain[MAX_KEYS].vld;
    assign table_full = (cnt_reg >= CNT_W'(MAX_KEYS));
    assign wr_now     = (state_reg == S_RUN) && tail_vld && prog_reg
                        && !chain[MAX_KEYS].hit && !table_full;
    assign out_load   = (state_reg == S_DONE) && (!out_vld_reg || result.ready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        stat_next      = stat_reg;
        start_next     = '0;
        start_next.key = key_in.key_id;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (key_in.read_ok)
                    begin
                        start_next.vld  = 1'b1;
                        start_next.left = cnt_reg;
                        state_next      = S_RUN;
                    end
                    else
                    begin
                        stat_next  = ST_READ_ERR;
                        state_next = S_DONE;
                    end
                end
            end
            S_RUN:
            begin
                if (tail_vld)
                begin
                    state_next = S_DONE;
                    if (chain[MAX_KEYS].hit)
                    begin
                        stat_next = prog_reg ? ST_KNOWN : ST_GRANTED;
                    end
                    else if (!prog_reg)
                    begin
                        stat_next = ST_DENIED;
                    end
                    else if (table_full)
                    begin
                        stat_next = ST_FULL;
                    end
                    else
                    begin
                        stat_next = ST_ADDED;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            start_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            start_reg   <= start_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg <= stat_next;
        if (in_acc)
        begin
            key_reg  <= key_in.key_id;
            ok_reg   <= key_in.read_ok;
            prog_reg <= key_in.program_mode;
        end
        if (out_load)
        begin
            out_stat_reg <= stat_reg;
            out_cnt_reg  <= KCNT_W'(cnt_reg);
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.status    = out_stat_reg;
    assign result.key_count = out_cnt_reg;

    // a walk only runs for a good read
    a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> ok_reg)
        else $error("lookup running for a failed read");

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_KEYS))
        else $error("key count beyond table size");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("key count changed by more than one");

    a_tail_run: assert property (@(posedge clk) disable iff (!rst_n)
        tail_vld |-> (state_reg == S_RUN))
        else $error("token left the row outside a lookup");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wr_sel))
        else $error("more than one cell written");

endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench: random and directed checking of the key whitelist lookup and enrollment block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import kwma_pkg::*;

    // Run sizing
    localparam int RANDOM_READS = 1380;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_PCT     = 14;
    // Window with no idling on either side, placed mid-run
    localparam int QUIET_FROM   = 40_000;
    localparam int QUIET_TO     = 90_000;
    localparam int MAX_PRINTS   = 20;

    // Bytes that count in a match, clamped to one..seven
    localparam int MATCH_BYTES = (KEY_BYTES > 7) ? 7 : ((KEY_BYTES < 1) ? 1 : KEY_BYTES);
    localparam logic [KEY_W-1:0] MATCH_MASK = KEY_W'((64'd1 << (8 * MATCH_BYTES)) - 64'd1);

    // Key-read word as sent on key_in
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             read_ok;
        logic             program_mode;
    } key_read_t;

    // Status word expected on result
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KCNT_W-1:0] key_count;
    } verdict_t;

    logic clk;
    logic rst_n;

    kwma_in_if  key_in_bus ();
    kwma_out_if result_bus ();

    key_whitelist_match_add_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .key_in (key_in_bus),
        .result (result_bus)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Stimulus and expectations
    key_read_t        reads_to_send [$];
    verdict_t         verdicts_due [$];
    logic [KEY_W-1:0] planned_keys [$];     // keys the stimulus expects to be enrolled

    // Shadow of the whitelist table
    logic [KEY_W-1:0] shadow_keys [MAX_KEYS];
    int               shadow_count;

    int        cycles;
    int        total_reads;
    int        reads_accepted;
    int        words_checked;
    int        mismatches;
    int        status_seen [6];
    int        peak_count;
    logic      in_took;
    key_read_t next_read;

    // One line per mismatch (capped), always counted
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] mismatch: %s got %0d expected %0d (word %0d)",
                     $time, what, got, want, words_checked);
        mismatches++;
    endtask

    // Lookup plus enrollment against the shadow table; updates it on an add
    function automatic verdict_t predict_verdict(input key_read_t rd);
        verdict_t v;
        logic     found;
        found = 1'b0;
        for (int i = 0; i < MAX_KEYS; i++)
            if (i < shadow_count && ((shadow_keys[i] ^ rd.key) & MATCH_MASK) == '0)
                found = 1'b1;
        if (!rd.read_ok)
            v.status = ST_READ_ERR;
        else if (!rd.program_mode)
            v.status = found ? ST_GRANTED : ST_DENIED;
        else if (found)
            v.status = ST_KNOWN;
        else if (shadow_count >= MAX_KEYS || shadow_count >= 255)
            v.status = ST_FULL;
        else
        begin
            shadow_keys[shadow_count] = rd.key;
            shadow_count++;
            v.status = ST_ADDED;
        end
        v.key_count = KCNT_W'(shadow_count);
        return v;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        return KEY_W'({$urandom, $urandom});
    endfunction

    // Queue a read; track keys that an enrollment should land in the table
    task automatic push_read(input logic [KEY_W-1:0] key, input logic ok, input logic prog);
        key_read_t rd;
        logic      seen;
        rd.key          = key;
        rd.read_ok      = ok;
        rd.program_mode = prog;
        reads_to_send.push_back(rd);
        total_reads++;
        if (ok && prog && planned_keys.size() < MAX_KEYS)
        begin
            seen = 1'b0;
            foreach (planned_keys[i])
                if (planned_keys[i] == key)
                    seen = 1'b1;
            if (!seen)
                planned_keys.push_back(key);
        end
    endtask

    // Random idle decision, off inside the quiet window
    function automatic logic idle_now();
        if (cycles >= QUIET_FROM && cycles < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // Driver: key_in changes on the falling edge only
    always @(negedge clk)
    begin
        if (!rst_n)
            key_in_bus.valid <= 1'b0;
        else if (!key_in_bus.valid || in_took)
        begin
            if (reads_to_send.size() > 0 && !idle_now())
            begin
                next_read = reads_to_send.pop_front();
                key_in_bus.key_id       <= next_read.key;
                key_in_bus.read_ok      <= next_read.read_ok;
                key_in_bus.program_mode <= next_read.program_mode;
                key_in_bus.valid        <= 1'b1;
            end
            else
                key_in_bus.valid <= 1'b0;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
            result_bus.ready <= !idle_now();
    end

    // Monitor: predicts on accepted key words, checks accepted status words
    always @(posedge clk)
    begin
        if (!rst_n)
            in_took <= 1'b0;
        else
        begin
            in_took <= key_in_bus.valid && key_in_bus.ready;
            if (key_in_bus.valid && key_in_bus.ready)
            begin
                next_read.key          = key_in_bus.key_id;
                next_read.read_ok      = key_in_bus.read_ok;
                next_read.program_mode = key_in_bus.program_mode;
                verdicts_due.push_back(predict_verdict(next_read));
                reads_accepted++;
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (verdicts_due.size() == 0)
                    report_mismatch("unexpected status word, status", result_bus.status, -1);
                else
                begin
                    verdict_t want;
                    want = verdicts_due.pop_front();
                    if (result_bus.status !== want.status)
                        report_mismatch("status", result_bus.status, want.status);
                    if (result_bus.key_count !== want.key_count)
                        report_mismatch("key_count", result_bus.key_count, want.key_count);
                end
                if (result_bus.status < 6)
                    status_seen[result_bus.status]++;
                if (result_bus.key_count > peak_count)
                    peak_count = result_bus.key_count;
                words_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d words accepted",
                     cycles, reads_accepted, total_reads);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int            pick;
        logic [KEY_W-1:0] k;

        rst_n                   = 1'b0;
        cycles                  = 0;
        total_reads             = 0;
        reads_accepted          = 0;
        words_checked           = 0;
        mismatches              = 0;
        peak_count              = 0;
        shadow_count            = 0;
        key_in_bus.valid        = 1'b0;
        key_in_bus.key_id       = '0;
        key_in_bus.read_ok      = 1'b0;
        key_in_bus.program_mode = 1'b0;
        result_bus.ready        = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Directed: failed reads on an empty table, lookups on empty table,
        // enrollment of the extreme keys, repeats, near misses, failed reads
        // of stored keys, then enrollment and lookup of top-bit and alternating-bit keys
        push_read({KEY_W{1'b1}}, 1'b0, 1'b0);
        push_read({KEY_W{1'b1}}, 1'b0, 1'b1);
        push_read('0, 1'b1, 1'b0);
        push_read({KEY_W{1'b1}}, 1'b1, 1'b0);
        push_read('0, 1'b1, 1'b1);
        push_read({KEY_W{1'b1}}, 1'b1, 1'b1);
        push_read('0, 1'b1, 1'b1);
        push_read({KEY_W{1'b1}}, 1'b1, 1'b1);
        push_read('0, 1'b1, 1'b0);
        push_read({KEY_W{1'b1}}, 1'b1, 1'b0);
        push_read(KEY_W'(1), 1'b1, 1'b0);                   // near miss, low bit
        push_read({1'b0, {(KEY_W-1){1'b1}}}, 1'b1, 1'b0);   // near miss, top bit
        push_read('0, 1'b0, 1'b1);                          // failed read of a stored key
        push_read('0, 1'b0, 1'b0);
        push_read({1'b1, {(KEY_W-1){1'b0}}}, 1'b1, 1'b1);
        push_read({1'b1, {(KEY_W-1){1'b0}}}, 1'b1, 1'b0);
        push_read({(KEY_W/2){2'b01}}, 1'b1, 1'b1);
        push_read({(KEY_W/2){2'b10}}, 1'b1, 1'b1);
        push_read({(KEY_W/2){2'b10}}, 1'b1, 1'b0);
        push_read({(KEY_W/2){2'b01}}, 1'b1, 1'b0);

        // Random: mostly real traffic against enrolled keys. Fresh enrollments
        // fill the table partway through, so the full-table case gets plenty
        // of hits afterwards.
        for (int n = 0; n < RANDOM_READS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (planned_keys.size() > 0)
                k = planned_keys[$urandom_range(0, planned_keys.size() - 1)];
            else
                k = random_key();
            if (pick < 8)
                push_read(random_key(), 1'b0, 1'($urandom_range(0, 1)));
            else if (pick < 40)
                push_read(random_key(), 1'b1, 1'b1);
            else if (pick < 58)
                push_read(k, 1'b1, 1'b1);
            else if (pick < 83)
                push_read(k, 1'b1, 1'b0);
            else if (pick < 92)
                push_read(k ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1)), 1'b1, 1'b0);
            else if (pick < 95)
                push_read(k, 1'b0, 1'($urandom_range(0, 1)));
            else
                push_read(random_key(), 1'b1, 1'b0);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (reads_accepted < total_reads || verdicts_due.size() > 0)
            @(posedge clk);
        // let any stray word surface
        repeat (MAX_KEYS + 8) @(posedge clk);

        if (verdicts_due.size() > 0)
            report_mismatch("status words never arrived, count", 0, verdicts_due.size());

        $display("%0d key words sent, %0d status words checked, table peaked at %0d keys",
                 total_reads, words_checked, peak_count);
        $display("read_err %0d, granted %0d, denied %0d, added %0d, known %0d, full %0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
src/kwma_pkg.sv
src/kwma_in_if.sv
src/kwma_out_if.sv
src/kwma_cell.sv
src/key_whitelist_match_add_top.sv
tb/tb.sv
